@@ rtl/mesh_vertex_normal_accumulator_defines.svh @@
// Assertion macros used by the checker file of the vertex normal block.
`ifndef MESH_VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define MVNA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mvna assertion failed in the next cycle");

// The consequent must hold in the same cycle as the antecedent.
`define MVNA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mvna assertion failed in the same cycle");

`endif

@@ rtl/mvna_pkg.sv @@
// Package with the shared types and constants of the vertex normal block.
package mvna_pkg;

   localparam int POS_W  = 16;
   localparam int IDX_W  = 10;
   localparam int SUM_W  = 20;
   localparam int NORM_W = 16;
   localparam int VEC_W  = 35;
   localparam int MAG_W  = 35;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_FACE = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic signed [SUM_W:0] SUM_MAX = 21'sd524287;
   localparam logic signed [SUM_W:0] SUM_MIN = -21'sd524288;

   typedef logic signed [VEC_W-1:0] vec_type;
   typedef logic signed [NORM_W-1:0] norm_type;

   typedef struct packed {
      norm_type x;
      norm_type y;
      norm_type z;
      logic     zero;
   } norm_result_type;

endpackage

@@ rtl/mvna_norm.sv @@
// Multi-cycle vector normalizer: shift, sum of squares, square root and division.
module mvna_norm import mvna_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  vec_type         vec_x,
   input  vec_type         vec_y,
   input  vec_type         vec_z,
   output norm_result_type result,
   output logic            done
);

   typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DLOAD, N_DIV} nstate_type;

   nstate_type          state_ff;
   logic [MAG_W-1:0]    mag_ff [3];
   logic                sgn_ff [3];
   logic [MAG_W-1:0]    m_ff;
   logic [1:0]          cnt_ff;
   logic [61:0]         prod_ff;
   logic [63:0]         s_ff;
   logic [63:0]         v_ff;
   logic [63:0]         r_ff;
   logic [63:0]         bit_ff;
   logic [32:0]         rem_ff;
   logic [14:0]         quot_ff;
   logic [3:0]          step_ff;
   logic [1:0]          k_ff;
   norm_type            res_ff [3];
   logic                zero_ff;
   logic                done_ff;

   logic [MAG_W-1:0]    mag_in [3];
   logic [MAG_W-1:0]    m_in;
   logic [30:0]         sq_in;
   logic [63:0]         trial_in;
   logic [31:0]         rem_in;
   logic                ge_in;
   logic [14:0]         qfin_in;

   always_comb begin
      mag_in[0] = vec_x[VEC_W-1] ? MAG_W'(-vec_x) : MAG_W'(vec_x);
      mag_in[1] = vec_y[VEC_W-1] ? MAG_W'(-vec_y) : MAG_W'(vec_y);
      mag_in[2] = vec_z[VEC_W-1] ? MAG_W'(-vec_z) : MAG_W'(vec_z);
      m_in = mag_in[0];
      if (mag_in[1] > m_in) begin
         m_in = mag_in[1];
      end
      if (mag_in[2] > m_in) begin
         m_in = mag_in[2];
      end
      case (cnt_ff)
         2'd0:    sq_in = mag_ff[0][30:0];
         2'd1:    sq_in = mag_ff[1][30:0];
         default: sq_in = mag_ff[2][30:0];
      endcase
      trial_in = r_ff + bit_ff;
      ge_in    = rem_ff >= {1'b0, r_ff[31:0]};
      rem_in   = ge_in ? 32'(rem_ff - {1'b0, r_ff[31:0]}) : rem_ff[31:0];
      qfin_in  = {quot_ff[13:0], ge_in};
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      unique case (state_ff)
         N_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= mag_in[i];
               end
               sgn_ff[0] <= vec_x[VEC_W-1];
               sgn_ff[1] <= vec_y[VEC_W-1];
               sgn_ff[2] <= vec_z[VEC_W-1];
               m_ff      <= m_in;
               if (m_in == '0) begin
                  for (int i = 0; i < 3; i++) begin
                     res_ff[i] <= '0;
                  end
                  zero_ff <= 1'b1;
                  done_ff <= 1'b1;
               end else begin
                  zero_ff  <= 1'b0;
                  state_ff <= N_SHIFT;
               end
            end
         end
         N_SHIFT: begin
            if (m_ff[MAG_W-1:31] != '0) begin
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= mag_ff[i] >> 1;
               end
               m_ff <= m_ff >> 1;
            end else if (!m_ff[30]) begin
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= mag_ff[i] << 1;
               end
               m_ff <= m_ff << 1;
            end else begin
               cnt_ff   <= 2'd0;
               s_ff     <= '0;
               state_ff <= N_SQ;
            end
         end
         N_SQ: begin
            prod_ff <= sq_in * sq_in;
            if (cnt_ff != 2'd0) begin
               s_ff <= s_ff + 64'(prod_ff);
            end
            if (cnt_ff == 2'd3) begin
               v_ff     <= s_ff + 64'(prod_ff);
               r_ff     <= '0;
               bit_ff   <= 64'd1 << 62;
               state_ff <= N_SQRT;
            end
            cnt_ff <= cnt_ff + 2'd1;
         end
         N_SQRT: begin
            if (v_ff >= trial_in) begin
               v_ff <= v_ff - trial_in;
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (bit_ff[0]) begin
               k_ff     <= 2'd0;
               state_ff <= N_DLOAD;
            end
         end
         N_DLOAD: begin
            case (k_ff)
               2'd0:    rem_ff <= 33'(mag_ff[0][30:0]);
               2'd1:    rem_ff <= 33'(mag_ff[1][30:0]);
               default: rem_ff <= 33'(mag_ff[2][30:0]);
            endcase
            quot_ff  <= '0;
            step_ff  <= '0;
            state_ff <= N_DIV;
         end
         N_DIV: begin
            rem_ff  <= {rem_in, 1'b0};
            quot_ff <= qfin_in;
            step_ff <= step_ff + 4'd1;
            if (step_ff == 4'd14) begin
               res_ff[k_ff] <= sgn_ff[k_ff] ? -norm_type'(qfin_in) : norm_type'(qfin_in);
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'd2) begin
                  done_ff  <= 1'b1;
                  state_ff <= N_IDLE;
               end else begin
                  state_ff <= N_DLOAD;
               end
            end
         end
         default: state_ff <= N_IDLE;
      endcase
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end
   end

   assign result = '{x: res_ff[0], y: res_ff[1], z: res_ff[2], zero: zero_ff};
   assign done   = done_ff;

endmodule

@@ rtl/mesh_vertex_normal_accumulator.sv @@
// Top level of the vertex normal block: position and sum memories with the item sequencer.
// Load words write the position memory; read and face words also use the normalizer.
// The normalizer shifts, then squares, then takes the square root and divides.
// One word is in flight at a time; the next is taken while a finished result waits.
// Reset clears control state only; memory entries are undefined until loaded.
module mesh_vertex_normal_accumulator import mvna_pkg::*; #(
   parameter int VERTEX_DEPTH = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_type,
   input  logic [IDX_W-1:0]        req_vertex_index,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   input  logic [IDX_W-1:0]        req_corner_a,
   input  logic [IDX_W-1:0]        req_corner_b,
   input  logic [IDX_W-1:0]        req_corner_c,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output norm_type                rsp_norm_x,
   output norm_type                rsp_norm_y,
   output norm_type                rsp_norm_z,
   output logic                    rsp_zero_length
);

   localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_POS_RD, S_POS_WAIT, S_DIFF, S_MUL, S_NORM,
      S_SUM_RD, S_SUM_WR, S_RSUM_RD, S_RSUM_WAIT, S_RESP
   } state_type;

   logic [3*POS_W-1:0] pos_mem [VERTEX_DEPTH];
   logic [3*SUM_W-1:0] sum_mem [VERTEX_DEPTH];

   state_type          state_ff;
   logic               face_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   cor_ff [3];
   logic [2:0]         cnt_ff;
   logic [3*POS_W-1:0] pos_ff [3];
   logic [3*POS_W-1:0] pos_q_ff;
   logic [3*SUM_W-1:0] sum_q_ff;
   logic signed [POS_W:0] d1_ff [3];
   logic signed [POS_W:0] d2_ff [3];
   logic signed [2*POS_W+1:0] prod_ff;
   vec_type            c_ff [3];
   logic               start_ff;
   norm_result_type    res_ff;
   logic               rsp_valid_ff;
   norm_result_type    rsp_ff;

   norm_result_type    norm_res;
   logic               norm_done;

   logic               accept_in;
   logic               load_ok_in;
   logic               face_ok_in;
   logic               read_ok_in;
   logic [AW-1:0]      pos_raddr_in;
   logic [AW-1:0]      sum_raddr_in;
   logic               sum_we_in;
   logic [AW-1:0]      sum_waddr_in;
   logic [3*SUM_W-1:0] sum_wdata_in;
   logic signed [POS_W:0] opa_in;
   logic signed [POS_W:0] opb_in;
   logic [2:0]         pidx_in;
   logic [1:0]         cj_in;

   function automatic logic in_range(input logic [IDX_W-1:0] idx);
      return 32'(idx) < 32'(VERTEX_DEPTH);
   endfunction

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s, input norm_type q);
      logic signed [SUM_W:0] t;
      t = $signed({s[SUM_W-1], s}) + (SUM_W+1)'(q);
      if (t > SUM_MAX) begin
         t = SUM_MAX;
      end else if (t < SUM_MIN) begin
         t = SUM_MIN;
      end
      return t[SUM_W-1:0];
   endfunction

   function automatic logic signed [POS_W:0] pos_diff(input logic [POS_W-1:0] p,
                                                      input logic [POS_W-1:0] r);
      return $signed({p[POS_W-1], p}) - $signed({r[POS_W-1], r});
   endfunction

   assign req_ready  = (state_ff == S_IDLE);
   assign accept_in  = req_valid && req_ready;
   assign load_ok_in = (req_type == REQ_LOAD) && in_range(req_vertex_index);
   assign face_ok_in = (req_type == REQ_FACE) && in_range(req_corner_a)
                       && in_range(req_corner_b) && in_range(req_corner_c);
   assign read_ok_in = (req_type == REQ_READ) && in_range(req_vertex_index);

   always_comb begin
      pos_raddr_in = AW'(cor_ff[cnt_ff[1:0]]);
      sum_raddr_in = (state_ff == S_RSUM_RD) ? AW'(idx_ff) : AW'(cor_ff[cnt_ff[1:0]]);
      if (accept_in && load_ok_in) begin
         sum_we_in    = 1'b1;
         sum_waddr_in = AW'(req_vertex_index);
         sum_wdata_in = '0;
      end else begin
         sum_we_in    = (state_ff == S_SUM_WR);
         sum_waddr_in = AW'(cor_ff[cnt_ff[1:0]]);
         sum_wdata_in = {sat_add(sum_q_ff[3*SUM_W-1:2*SUM_W], res_ff.z),
                         sat_add(sum_q_ff[2*SUM_W-1:SUM_W], res_ff.y),
                         sat_add(sum_q_ff[SUM_W-1:0], res_ff.x)};
      end
      case (cnt_ff)
         3'd0:    begin opa_in = d1_ff[1]; opb_in = d2_ff[2]; end
         3'd1:    begin opa_in = d1_ff[2]; opb_in = d2_ff[1]; end
         3'd2:    begin opa_in = d1_ff[2]; opb_in = d2_ff[0]; end
         3'd3:    begin opa_in = d1_ff[0]; opb_in = d2_ff[2]; end
         3'd4:    begin opa_in = d1_ff[0]; opb_in = d2_ff[1]; end
         default: begin opa_in = d1_ff[1]; opb_in = d2_ff[0]; end
      endcase
      pidx_in = cnt_ff - 3'd1;
      cj_in   = pidx_in[2:1];
   end

   always_ff @(posedge clock) begin
      if (accept_in && load_ok_in) begin
         pos_mem[AW'(req_vertex_index)] <= {req_pos_z, req_pos_y, req_pos_x};
      end
      pos_q_ff <= pos_mem[pos_raddr_in];
   end

   always_ff @(posedge clock) begin
      if (sum_we_in) begin
         sum_mem[sum_waddr_in] <= sum_wdata_in;
      end
      sum_q_ff <= sum_mem[sum_raddr_in];
   end

   mvna_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .vec_x  (c_ff[0]),
      .vec_y  (c_ff[1]),
      .vec_z  (c_ff[2]),
      .result (norm_res),
      .done   (norm_done)
   );

   always_ff @(posedge clock) begin
      start_ff <= 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept_in) begin
               idx_ff    <= req_vertex_index;
               cor_ff[0] <= req_corner_a;
               cor_ff[1] <= req_corner_b;
               cor_ff[2] <= req_corner_c;
               cnt_ff    <= '0;
               res_ff    <= '0;
               face_ff   <= face_ok_in;
               if (face_ok_in) begin
                  state_ff <= S_POS_RD;
               end else if (read_ok_in) begin
                  state_ff <= S_RSUM_RD;
               end else begin
                  state_ff <= S_RESP;
               end
            end
         end
         S_POS_RD: state_ff <= S_POS_WAIT;
         S_POS_WAIT: begin
            pos_ff[cnt_ff[1:0]] <= pos_q_ff;
            if (cnt_ff == 3'd2) begin
               state_ff <= S_DIFF;
            end else begin
               cnt_ff   <= cnt_ff + 3'd1;
               state_ff <= S_POS_RD;
            end
         end
         S_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               d1_ff[i] <= pos_diff(pos_ff[1][i*POS_W +: POS_W], pos_ff[0][i*POS_W +: POS_W]);
               d2_ff[i] <= pos_diff(pos_ff[2][i*POS_W +: POS_W], pos_ff[0][i*POS_W +: POS_W]);
            end
            cnt_ff   <= '0;
            state_ff <= S_MUL;
         end
         S_MUL: begin
            prod_ff <= opa_in * opb_in;
            if (cnt_ff != 3'd0) begin
               if (!pidx_in[0]) begin
                  c_ff[cj_in] <= VEC_W'(prod_ff);
               end else begin
                  c_ff[cj_in] <= c_ff[cj_in] - VEC_W'(prod_ff);
               end
            end
            if (cnt_ff == 3'd6) begin
               start_ff <= 1'b1;
               state_ff <= S_NORM;
            end else begin
               cnt_ff <= cnt_ff + 3'd1;
            end
         end
         S_NORM: begin
            if (norm_done) begin
               cnt_ff <= '0;
               if (face_ff) begin
                  res_ff   <= '{x: -norm_res.x, y: -norm_res.y, z: -norm_res.z,
                                zero: norm_res.zero};
                  state_ff <= S_SUM_RD;
               end else begin
                  res_ff   <= norm_res;
                  state_ff <= S_RESP;
               end
            end
         end
         S_SUM_RD: state_ff <= S_SUM_WR;
         S_SUM_WR: begin
            if (cnt_ff == 3'd2) begin
               state_ff <= S_RESP;
            end else begin
               cnt_ff   <= cnt_ff + 3'd1;
               state_ff <= S_SUM_RD;
            end
         end
         S_RSUM_RD: state_ff <= S_RSUM_WAIT;
         S_RSUM_WAIT: begin
            for (int i = 0; i < 3; i++) begin
               c_ff[i] <= VEC_W'($signed(sum_q_ff[i*SUM_W +: SUM_W]));
            end
            start_ff <= 1'b1;
            state_ff <= S_NORM;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_ff       <= res_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
         end
         default: state_ff <= S_IDLE;
      endcase
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         start_ff     <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_norm_x      = rsp_ff.x;
   assign rsp_norm_y      = rsp_ff.y;
   assign rsp_norm_z      = rsp_ff.z;
   assign rsp_zero_length = rsp_ff.zero;

endmodule

@@ rtl/mvna_checker.sv @@
// Port checker for the vertex normal block and its bind statement.
`include "mesh_vertex_normal_accumulator_defines.svh"

module mvna_port_checker import mvna_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [NORM_W-1:0] rsp_norm_x,
   input logic signed [NORM_W-1:0] rsp_norm_y,
   input logic signed [NORM_W-1:0] rsp_norm_z,
   input logic                    rsp_zero_length
);

   logic [3*NORM_W:0] rsp_word;
   logic              rsp_norm_zero;
   logic              rsp_norm_unit;

   function automatic logic in_unit(input logic signed [NORM_W-1:0] v);
      return (v >= -16'sd16384) && (v <= 16'sd16384);
   endfunction

   assign rsp_word      = {rsp_norm_x, rsp_norm_y, rsp_norm_z, rsp_zero_length};
   assign rsp_norm_zero = (rsp_norm_x == '0) && (rsp_norm_y == '0) && (rsp_norm_z == '0);
   assign rsp_norm_unit = in_unit(rsp_norm_x) && in_unit(rsp_norm_y) && in_unit(rsp_norm_z);

   `MVNA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))
   `MVNA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `MVNA_ASSERT_NOW(a_zero_flag, clock, reset, rsp_valid && rsp_zero_length, rsp_norm_zero)
   `MVNA_ASSERT_NOW(a_unit_range, clock, reset, rsp_valid, rsp_norm_unit)

endmodule

bind mesh_vertex_normal_accumulator mvna_port_checker u_mvna_checker (.*);
